// ----- sv/ray_sfi_pkg.sv -----
// Package for the ray / simplex face intersection block.
// Shared constants, result codes and the sideband struct; no dependencies.
package ray_sfi_pkg;

  localparam int IN_W          = 63;
  localparam int RES_W         = 32;
  localparam int DEF_COORD_BITS = 21;
  localparam int DEF_FRAC_BITS  = 16;
  // quotient bits kept by the divider; enough to detect saturation
  localparam int QB            = RES_W + 1;
  localparam int DIV_LAT       = QB + 2;

  localparam logic [1:0] DIMS_2D    = 2'd2;
  localparam logic [1:0] DIMS_RESET = 2'd3;

  localparam logic signed [1:0] ORIENT_EXIT     = 2'sb01;
  localparam logic signed [1:0] ORIENT_ENTRY    = 2'sb11;
  localparam logic signed [1:0] ORIENT_PARALLEL = 2'sb00;

  typedef struct packed {
    logic              valid;
    logic signed [1:0] orient;
    logic              degen;
    logic              gate;
    logic              three;
  } side_t;

endpackage

// ----- sv/ray_sfi_front.sv -----
// Geometry front end: edge vectors, cross products and dot products.
// Three register stages; depends on ray_sfi_pkg.
module ray_sfi_front import ray_sfi_pkg::*; #(
  parameter int COORD_BITS = DEF_COORD_BITS,
  localparam int DW = COORD_BITS + 1,
  localparam int NW = 2 * DW + 1,
  localparam int AW = NW + DW + 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic                 three_i,
  input  logic [IN_W-1:0]      ray_origin_i,
  input  logic [IN_W-1:0]      ray_direction_i,
  input  logic [IN_W-1:0]      vertex_a_i,
  input  logic [IN_W-1:0]      vertex_b_i,
  input  logic [IN_W-1:0]      vertex_c_i,
  input  logic [IN_W-1:0]      cell_centre_i,
  output logic                 valid_o,
  output logic                 three_o,
  output logic                 degen_o,
  output logic signed [AW-1:0] dn_o,
  output logic signed [AW-1:0] num_o,
  output logic signed [AW-1:0] tst_o,
  output logic signed [AW-1:0] bden_o,
  output logic signed [AW-1:0] bn1_o,
  output logic signed [AW-1:0] bn2_o
);

  function automatic logic signed [DW-1:0] ext(input logic [COORD_BITS-1:0] v);
    ext = DW'($signed(v));
  endfunction

  function automatic logic signed [NW-1:0] mul_n(input logic signed [DW-1:0] a,
                                                 input logic signed [DW-1:0] b);
    mul_n = NW'(a) * NW'(b);
  endfunction

  function automatic logic signed [AW-1:0] dot3(
    input logic signed [NW-1:0] x0, input logic signed [NW-1:0] x1,
    input logic signed [NW-1:0] x2, input logic signed [DW-1:0] y0,
    input logic signed [DW-1:0] y1, input logic signed [DW-1:0] y2);
    dot3 = AW'(x0) * AW'(y0) + AW'(x1) * AW'(y1) + AW'(x2) * AW'(y2);
  endfunction

  // stage 1: unpack and differences
  logic signed [DW-1:0] o_c[3], d_c[3], a_c[3], b_c[3], c_c[3], m_c[3];
  logic signed [DW-1:0] d1_d[3], e1_d[3], e2_d[3], s_d[3], ao_d[3], am_d[3];
  logic signed [DW-1:0] d1_q[3], e1_q[3], e2_q[3], s_q[3], ao_q[3], am_q[3];
  logic                 v1_q, t1_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      o_c[k] = ext(ray_origin_i[k*COORD_BITS +: COORD_BITS]);
      d_c[k] = ext(ray_direction_i[k*COORD_BITS +: COORD_BITS]);
      a_c[k] = ext(vertex_a_i[k*COORD_BITS +: COORD_BITS]);
      b_c[k] = ext(vertex_b_i[k*COORD_BITS +: COORD_BITS]);
      c_c[k] = ext(vertex_c_i[k*COORD_BITS +: COORD_BITS]);
      m_c[k] = ext(cell_centre_i[k*COORD_BITS +: COORD_BITS]);
      if (!three_i && k == 2) begin
        o_c[k] = '0; d_c[k] = '0; a_c[k] = '0;
        b_c[k] = '0; c_c[k] = '0; m_c[k] = '0;
      end
      d1_d[k] = d_c[k];
      e1_d[k] = b_c[k] - a_c[k];
      e2_d[k] = c_c[k] - a_c[k];
      s_d[k]  = o_c[k] - a_c[k];
      ao_d[k] = a_c[k] - o_c[k];
      am_d[k] = a_c[k] - m_c[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q <= three_i;
      d1_q <= d1_d; e1_q <= e1_d; e2_q <= e2_d;
      s_q  <= s_d;  ao_q <= ao_d; am_q <= am_d;
    end
  end

  // stage 2: normal and the two auxiliary cross products
  logic signed [NW-1:0] n_d[3], pv_d[3], qv_d[3];
  logic signed [NW-1:0] n_q[3], pv_q[3], qv_q[3];
  logic signed [DW-1:0] d2_q[3], e12_q[3], s2_q[3], ao2_q[3], am2_q[3];
  logic                 v2_q, t2_q;

  always_comb begin
    if (t1_q) begin
      n_d[0]  = mul_n(e1_q[1], e2_q[2]) - mul_n(e1_q[2], e2_q[1]);
      n_d[1]  = mul_n(e1_q[2], e2_q[0]) - mul_n(e1_q[0], e2_q[2]);
      n_d[2]  = mul_n(e1_q[0], e2_q[1]) - mul_n(e1_q[1], e2_q[0]);
      pv_d[0] = mul_n(d1_q[1], e2_q[2]) - mul_n(d1_q[2], e2_q[1]);
      pv_d[1] = mul_n(d1_q[2], e2_q[0]) - mul_n(d1_q[0], e2_q[2]);
      pv_d[2] = mul_n(d1_q[0], e2_q[1]) - mul_n(d1_q[1], e2_q[0]);
      qv_d[0] = mul_n(s_q[1], e1_q[2]) - mul_n(s_q[2], e1_q[1]);
      qv_d[1] = mul_n(s_q[2], e1_q[0]) - mul_n(s_q[0], e1_q[2]);
      qv_d[2] = mul_n(s_q[0], e1_q[1]) - mul_n(s_q[1], e1_q[0]);
    end else begin
      // segment face: perpendicular of the edge; pv turns s.pv into s x d
      n_d[0]  = -NW'(e1_q[1]);
      n_d[1]  = NW'(e1_q[0]);
      n_d[2]  = '0;
      pv_d[0] = NW'(d1_q[1]);
      pv_d[1] = -NW'(d1_q[0]);
      pv_d[2] = '0;
      qv_d[0] = '0;
      qv_d[1] = '0;
      qv_d[2] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t2_q <= t1_q;
      n_q <= n_d; pv_q <= pv_d; qv_q <= qv_d;
      d2_q <= d1_q; e12_q <= e1_q; s2_q <= s_q; ao2_q <= ao_q; am2_q <= am_q;
    end
  end

  // stage 3: dot products
  logic signed [AW-1:0] dn_c, bden3_c;
  logic                 v3_q, t3_q, dg3_q;
  logic signed [AW-1:0] dn_q, num_q, tst_q, bden_q, bn1_q, bn2_q;

  assign dn_c    = dot3(n_q[0], n_q[1], n_q[2], d2_q[0], d2_q[1], d2_q[2]);
  assign bden3_c = dot3(pv_q[0], pv_q[1], pv_q[2], e12_q[0], e12_q[1], e12_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t3_q   <= t2_q;
      dg3_q  <= (n_q[0] == '0) && (n_q[1] == '0) && (n_q[2] == '0);
      dn_q   <= dn_c;
      num_q  <= dot3(n_q[0], n_q[1], n_q[2], ao2_q[0], ao2_q[1], ao2_q[2]);
      tst_q  <= dot3(n_q[0], n_q[1], n_q[2], am2_q[0], am2_q[1], am2_q[2]);
      bden_q <= t2_q ? bden3_c : dn_c;
      bn1_q  <= dot3(pv_q[0], pv_q[1], pv_q[2], s2_q[0], s2_q[1], s2_q[2]);
      bn2_q  <= t2_q ? dot3(qv_q[0], qv_q[1], qv_q[2], d2_q[0], d2_q[1], d2_q[2])
                     : '0;
    end
  end

  assign valid_o = v3_q;
  assign three_o = t3_q;
  assign degen_o = dg3_q;
  assign dn_o    = dn_q;
  assign num_o   = num_q;
  assign tst_o   = tst_q;
  assign bden_o  = bden_q;
  assign bn1_o   = bn1_q;
  assign bn2_o   = bn2_q;

endmodule

// ----- sv/ray_sfi_div.sv -----
// Pipelined restoring divider: round(num * 2^FRAC_BITS / den), saturated.
// One quotient bit per stage; depends on ray_sfi_pkg.
module ray_sfi_div import ray_sfi_pkg::*; #(
  parameter int AW        = 69,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [AW-1:0]    num_i,
  input  logic signed [AW-1:0]    den_i,
  output logic signed [RES_W-1:0] quo_o
);

  localparam int NWD = AW + FRAC_BITS + 1;
  localparam logic [QB-1:0] LIM_POS = QB'(33'h0_7fff_ffff);
  localparam logic [QB-1:0] LIM_NEG = LIM_POS + QB'(1);

  logic [AW-1:0]  ma_c, mb_c;
  logic [NWD-1:0] nfull_c;
  logic           ovf_c;

  assign ma_c    = num_i[AW-1] ? (~num_i + AW'(1)) : num_i;
  assign mb_c    = den_i[AW-1] ? (~den_i + AW'(1)) : den_i;
  assign nfull_c = {ma_c, {(FRAC_BITS + 1){1'b0}}};
  assign ovf_c   = {{(AW + QB - NWD){1'b0}}, nfull_c} >= {mb_c, {QB{1'b0}}};

  logic [AW-1:0] r_q[QB+1];
  logic [AW-1:0] mb_q[QB+1];
  logic [QB-1:0] lb_q[QB+1];
  logic [QB-1:0] q_q[QB+1];
  logic          neg_q[QB+1], ovf_q[QB+1], zero_q[QB+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]    <= AW'(nfull_c >> QB);
      mb_q[0]   <= mb_c;
      lb_q[0]   <= nfull_c[QB-1:0];
      q_q[0]    <= '0;
      neg_q[0]  <= num_i[AW-1] ^ den_i[AW-1];
      ovf_q[0]  <= ovf_c;
      zero_q[0] <= (mb_c == '0);
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [AW:0] t_c, diff_c;
    logic        ge_c;
    assign t_c    = {r_q[k], lb_q[k][QB-1]};
    assign ge_c   = t_c >= {1'b0, mb_q[k]};
    assign diff_c = t_c - {1'b0, mb_q[k]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k+1]    <= ge_c ? diff_c[AW-1:0] : t_c[AW-1:0];
        mb_q[k+1]   <= mb_q[k];
        lb_q[k+1]   <= lb_q[k] << 1;
        q_q[k+1]    <= {q_q[k][QB-2:0], ge_c};
        neg_q[k+1]  <= neg_q[k];
        ovf_q[k+1]  <= ovf_q[k];
        zero_q[k+1] <= zero_q[k];
      end
    end
  end

  logic [QB:0]    qinc_c;
  logic [QB-1:0]  qr_c, lim_c, mag_c;
  logic [RES_W-1:0] res_c, quo_q;

  always_comb begin
    qinc_c = {1'b0, q_q[QB]} + (QB+1)'(1);
    qr_c   = qinc_c[QB:1];
    lim_c  = neg_q[QB] ? LIM_NEG : LIM_POS;
    mag_c  = (ovf_q[QB] || qr_c > lim_c) ? lim_c : qr_c;
    if (zero_q[QB]) begin
      res_c = '0;
    end else if (neg_q[QB]) begin
      res_c = RES_W'(~mag_c + QB'(1));
    end else begin
      res_c = RES_W'(mag_c);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q <= res_c;
    end
  end

  assign quo_o = quo_q;

endmodule

// ----- sv/ray_sfi_back.sv -----
// Back end: vertex-0 weight, collision parameter, gating and output register.
// Two register stages; depends on ray_sfi_pkg.
module ray_sfi_back import ray_sfi_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  side_t                   side_i,
  input  logic signed [RES_W-1:0] dist_i,
  input  logic signed [RES_W-1:0] b1_i,
  input  logic signed [RES_W-1:0] b2_i,
  output logic                    valid_o,
  output logic signed [1:0]       orientation_o,
  output logic signed [RES_W-1:0] distance_o,
  output logic signed [RES_W-1:0] bary_a_o,
  output logic signed [RES_W-1:0] bary_b_o,
  output logic signed [RES_W-1:0] bary_c_o,
  output logic signed [RES_W-1:0] closeness_o,
  output logic                    degenerate_o
);

  localparam int XW = RES_W + 2;
  localparam logic signed [XW-1:0] ONE  = XW'(1) <<< FRAC_BITS;
  localparam logic signed [XW-1:0] HALF = XW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [XW-1:0] SMAX = XW'(32'sh7fff_ffff);
  localparam logic signed [XW-1:0] SMIN = -SMAX - XW'(1);

  function automatic logic signed [RES_W-1:0] sat32(input logic signed [XW-1:0] v);
    if (v > SMAX) begin
      sat32 = RES_W'(SMAX);
    end else if (v < SMIN) begin
      sat32 = RES_W'(SMIN);
    end else begin
      sat32 = RES_W'(v);
    end
  endfunction

  function automatic logic signed [XW-1:0] cand(input logic signed [RES_W-1:0] w);
    logic signed [XW-1:0] wx;
    wx = XW'(w);
    cand = (wx < HALF) ? wx : ONE - wx;
  endfunction

  // stage 1: gated weights
  logic signed [RES_W-1:0] b1g_c, b2g_c;
  side_t                   s1_q;
  logic signed [RES_W-1:0] dist1_q, b0_q, b1_q, b2_q;

  assign b1g_c = side_i.gate ? b1_i : '0;
  assign b2g_c = (side_i.gate && side_i.three) ? b2_i : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else if (en_i) begin
      s1_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dist1_q <= side_i.gate ? dist_i : '0;
      b1_q    <= b1g_c;
      b2_q    <= b2g_c;
      b0_q    <= side_i.gate ? sat32(ONE - XW'(b1g_c) - XW'(b2g_c)) : '0;
    end
  end

  // stage 2: collision parameter, output register
  logic signed [XW-1:0]    c0_c, c1_c, c2_c, m01_c, m_c;
  logic                    v2_q, dg2_q;
  logic signed [1:0]       or2_q;
  logic signed [RES_W-1:0] dist2_q, ba_q, bb_q, bc_q, cl_q;

  always_comb begin
    c0_c  = cand(b0_q);
    c1_c  = cand(b1_q);
    c2_c  = cand(b2_q);
    m01_c = (c1_c < c0_c) ? c1_c : c0_c;
    m_c   = (s1_q.three && c2_c < m01_c) ? c2_c : m01_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= s1_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      or2_q   <= s1_q.orient;
      dg2_q   <= s1_q.degen;
      dist2_q <= dist1_q;
      ba_q    <= b0_q;
      bb_q    <= b1_q;
      bc_q    <= b2_q;
      cl_q    <= s1_q.gate ? sat32(m_c) : '0;
    end
  end

  assign valid_o       = v2_q;
  assign orientation_o = or2_q;
  assign distance_o    = dist2_q;
  assign bary_a_o      = ba_q;
  assign bary_b_o      = bb_q;
  assign bary_c_o      = bc_q;
  assign closeness_o   = cl_q;
  assign degenerate_o  = dg2_q;

endmodule

// ----- sv/ray_simplex_face_intersect_top.sv -----
// Top level of the ray / simplex face intersection pipeline.
// Instantiates ray_sfi_front, three ray_sfi_div and ray_sfi_back; uses ray_sfi_pkg.
//
// Input channel: in_valid_i / in_stall_o with the six packed Q10.10 fields;
// a transfer happens on a clock edge with valid high and stall low.
// Output channel: out_valid_o / out_stall_i with orientation, distance,
// three barycentric weights, closeness and the degenerate flag.
// Config channel: cfg_valid_i / cfg_ready_o writes num_dims (always ready);
// write it only while the pipeline is empty.
// Throughput: one item per cycle while the receiver does not stall. The
// pipeline is three geometry stages, the one-bit-per-stage dividers of the
// ray parameter and the weights, and two output stages.
// The whole pipeline advances together; when the receiver stalls a valid
// result, every stage holds and in_stall_o is raised in the same cycle.
// Reset empties the pipeline and sets num_dims to 3.
module ray_simplex_face_intersect_top import ray_sfi_pkg::*; #(
  parameter int COORD_BITS       = DEF_COORD_BITS,
  parameter int RESULT_FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [1:0]              cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [IN_W-1:0]         ray_origin_i,
  input  logic [IN_W-1:0]         ray_direction_i,
  input  logic [IN_W-1:0]         vertex_a_i,
  input  logic [IN_W-1:0]         vertex_b_i,
  input  logic [IN_W-1:0]         vertex_c_i,
  input  logic [IN_W-1:0]         cell_centre_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [1:0]       orientation_o,
  output logic signed [RES_W-1:0] distance_o,
  output logic signed [RES_W-1:0] bary_a_o,
  output logic signed [RES_W-1:0] bary_b_o,
  output logic signed [RES_W-1:0] bary_c_o,
  output logic signed [RES_W-1:0] closeness_o,
  output logic                    degenerate_o
);

  localparam int DW = COORD_BITS + 1;
  localparam int AW = 3 * DW + 3;

  logic       en;
  logic [1:0] num_dims_q;

  assign en          = !out_valid_o || !out_stall_i;
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dims_q <= DIMS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      num_dims_q <= cfg_data_i;
    end
  end

  logic                 f_valid, f_three, f_degen;
  logic signed [AW-1:0] dn, num, tst, bden, bn1, bn2;

  ray_sfi_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i, .rst_ni,
    .en_i            (en),
    .valid_i         (in_valid_i),
    .three_i         (num_dims_q != DIMS_2D),
    .ray_origin_i, .ray_direction_i, .vertex_a_i, .vertex_b_i, .vertex_c_i,
    .cell_centre_i,
    .valid_o         (f_valid),
    .three_o         (f_three),
    .degen_o         (f_degen),
    .dn_o            (dn),
    .num_o           (num),
    .tst_o           (tst),
    .bden_o          (bden),
    .bn1_o           (bn1),
    .bn2_o           (bn2)
  );

  side_t side_c;
  side_t side_q[DIV_LAT];

  always_comb begin
    side_c.valid  = f_valid;
    side_c.degen  = f_degen;
    side_c.three  = f_three;
    side_c.gate   = !f_degen && (dn != '0);
    if (!side_c.gate) begin
      side_c.orient = ORIENT_PARALLEL;
    end else if (dn[AW-1] ^ tst[AW-1]) begin
      side_c.orient = ORIENT_ENTRY;
    end else begin
      side_c.orient = ORIENT_EXIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        side_q[k] <= '0;
      end
    end else if (en) begin
      side_q[0] <= side_c;
      for (int k = 1; k < DIV_LAT; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  logic signed [RES_W-1:0] q_dist, q_b1, q_b2;

  ray_sfi_div #(.AW(AW), .FRAC_BITS(RESULT_FRAC_BITS)) u_div_dist (
    .clk_i, .en_i(en), .num_i(num), .den_i(dn), .quo_o(q_dist)
  );

  ray_sfi_div #(.AW(AW), .FRAC_BITS(RESULT_FRAC_BITS)) u_div_b1 (
    .clk_i, .en_i(en), .num_i(bn1), .den_i(bden), .quo_o(q_b1)
  );

  ray_sfi_div #(.AW(AW), .FRAC_BITS(RESULT_FRAC_BITS)) u_div_b2 (
    .clk_i, .en_i(en), .num_i(bn2), .den_i(bden), .quo_o(q_b2)
  );

  ray_sfi_back #(.FRAC_BITS(RESULT_FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .en_i          (en),
    .side_i        (side_q[DIV_LAT-1]),
    .dist_i        (q_dist),
    .b1_i          (q_b1),
    .b2_i          (q_b2),
    .valid_o       (out_valid_o),
    .orientation_o, .distance_o, .bary_a_o, .bary_b_o, .bary_c_o,
    .closeness_o, .degenerate_o
  );

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |->
      orientation_o == ORIENT_PARALLEL && distance_o == '0 && closeness_o == '0)
    else $error("degenerate face with nonzero results");

  a_parallel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && orientation_o == ORIENT_PARALLEL |->
      distance_o == '0 && bary_b_o == '0 && bary_c_o == '0)
    else $error("parallel face with nonzero results");

  a_orient_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> orientation_o != 2'sb10)
    else $error("bad orientation code");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(side_q[DIV_LAT-1]))
    else $error("pipeline moved during stall");

endmodule

// ----- dv/tb_ray_simplex_face_intersect_top.sv -----
// Testbench for ray_simplex_face_intersect_top: directed and random ray / face items
// checked against an in-bench predictor of orientation, distance and weights.
// Depends on ray_sfi_pkg and the RTL of the top level only.
`timescale 1ns / 1ps

module tb_ray_simplex_face_intersect_top;
  import ray_sfi_pkg::*;

  localparam int CB = DEF_COORD_BITS;
  localparam int FB = DEF_FRAC_BITS;
  localparam int SETTLE = DIV_LAT + 20;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [IN_W-1:0] org, dir, va, vb, vc, ctr;
  } face_item_t;

  typedef struct {
    logic signed [1:0] orient;
    logic [31:0] dst, ba, bb, bc, close;
    logic degen;
  } hit_t;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_data;
  logic in_valid, in_stall;
  face_item_t cur;
  logic out_valid, out_stall;
  logic signed [1:0] orientation;
  logic signed [31:0] distance, bary_a, bary_b, bary_c, closeness;
  logic degenerate;

  logic [1:0] dims;
  hit_t hits_q[$];
  int errors;
  int stall_pct;
  int gap_max;
  int burst_left;

  ray_simplex_face_intersect_top DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .ray_origin_i(cur.org), .ray_direction_i(cur.dir),
    .vertex_a_i(cur.va), .vertex_b_i(cur.vb), .vertex_c_i(cur.vc),
    .cell_centre_i(cur.ctr),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .orientation_o(orientation), .distance_o(distance),
    .bary_a_o(bary_a), .bary_b_o(bary_b), .bary_c_o(bary_c),
    .closeness_o(closeness), .degenerate_o(degenerate)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("ray_simplex_face_intersect_top: mismatch");
    $finish;
  end

  function automatic wide_t crd(logic [IN_W-1:0] p, int k);
    logic signed [CB-1:0] v;
    wide_t r;
    v = p[k*CB +: CB];
    r = 128'(v);
    return r;
  endfunction

  function automatic logic signed [63:0] sat32(logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  // round(a * 2^FB / b), ties away from zero, saturated
  function automatic logic signed [63:0] ratio_q16(wide_t a, wide_t b);
    logic [127:0] ma, mb, q, lim;
    logic neg;
    if (b == 0) return 0;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    q = (((ma << (FB + 1)) / mb) + 1) >> 1;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (q > lim) q = lim;
    return neg ? -$signed({1'b0, q[62:0]}) : $signed({1'b0, q[62:0]});
  endfunction

  function automatic hit_t trace_face(face_item_t it, logic [1:0] nd);
    wide_t o[3], d[3], a[3], b[3], c[3], m[3];
    wide_t e1[3], e2[3], s[3], ao[3], am[3], n[3], pv[3], qv[3];
    wide_t dn, num, tst, bn1, bn2, bden;
    logic signed [63:0] one, half, w[3], cand, cl, b0, b1, b2, tpar;
    logic three;
    int cnt;
    hit_t h;
    three = (nd != DIMS_2D);
    for (int k = 0; k < 3; k++) begin
      o[k] = crd(it.org, k); d[k] = crd(it.dir, k);
      a[k] = crd(it.va, k); b[k] = crd(it.vb, k);
      c[k] = crd(it.vc, k); m[k] = crd(it.ctr, k);
      if (!three && k == 2) begin
        o[k] = 0; d[k] = 0; a[k] = 0; b[k] = 0; c[k] = 0; m[k] = 0;
      end
    end
    for (int k = 0; k < 3; k++) begin
      e1[k] = b[k] - a[k]; e2[k] = c[k] - a[k];
      s[k] = o[k] - a[k]; ao[k] = a[k] - o[k]; am[k] = a[k] - m[k];
    end
    bn2 = 0;
    if (three) begin
      for (int k = 0; k < 3; k++) begin
        n[k]  = e1[(k+1)%3] * e2[(k+2)%3] - e1[(k+2)%3] * e2[(k+1)%3];
        pv[k] = d[(k+1)%3] * e2[(k+2)%3] - d[(k+2)%3] * e2[(k+1)%3];
        qv[k] = s[(k+1)%3] * e1[(k+2)%3] - s[(k+2)%3] * e1[(k+1)%3];
      end
      bden = e1[0]*pv[0] + e1[1]*pv[1] + e1[2]*pv[2];
      bn1 = s[0]*pv[0] + s[1]*pv[1] + s[2]*pv[2];
      bn2 = d[0]*qv[0] + d[1]*qv[1] + d[2]*qv[2];
    end else begin
      n[0] = -e1[1]; n[1] = e1[0]; n[2] = 0;
      bn1 = s[0]*d[1] - s[1]*d[0];
    end
    h.degen = (n[0] == 0 && n[1] == 0 && n[2] == 0);
    dn = n[0]*d[0] + n[1]*d[1] + n[2]*d[2];
    num = n[0]*ao[0] + n[1]*ao[1] + n[2]*ao[2];
    tst = n[0]*am[0] + n[1]*am[1] + n[2]*am[2];
    if (!three) bden = dn;
    h.orient = ORIENT_PARALLEL;
    tpar = 0; b0 = 0; b1 = 0; b2 = 0; cl = 0;
    if (!h.degen && dn != 0) begin
      one = 64'sd1 <<< FB;
      half = 64'sd1 <<< (FB - 1);
      h.orient = ((dn > 0) == (tst >= 0)) ? ORIENT_EXIT : ORIENT_ENTRY;
      tpar = ratio_q16(num, dn);
      b1 = ratio_q16(bn1, bden);
      b2 = three ? ratio_q16(bn2, bden) : 0;
      b0 = sat32(one - b1 - b2);
      w[0] = b0; w[1] = b1; w[2] = b2;
      cnt = three ? 3 : 2;
      for (int i = 0; i < cnt; i++) begin
        cand = (w[i] < half) ? w[i] : one - w[i];
        if (i == 0 || cand < cl) cl = cand;
      end
      cl = sat32(cl);
    end
    h.dst = tpar[31:0]; h.ba = b0[31:0]; h.bb = b1[31:0];
    h.bc = b2[31:0]; h.close = cl[31:0];
    return h;
  endfunction

  // result checker
  always @(posedge clk) begin
    hit_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (hits_q.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        e = hits_q.pop_front();
        if (orientation !== e.orient) begin
          $error("orientation exp %0d got %0d", e.orient, orientation); errors++;
        end
        if (distance !== e.dst) begin
          $error("distance exp %h got %h", e.dst, distance); errors++;
        end
        if (bary_a !== e.ba) begin
          $error("bary_a exp %h got %h", e.ba, bary_a); errors++;
        end
        if (bary_b !== e.bb) begin
          $error("bary_b exp %h got %h", e.bb, bary_b); errors++;
        end
        if (bary_c !== e.bc) begin
          $error("bary_c exp %h got %h", e.bc, bary_c); errors++;
        end
        if (closeness !== e.close) begin
          $error("closeness exp %h got %h", e.close, closeness); errors++;
        end
        if (degenerate !== e.degen) begin
          $error("degenerate exp %b got %b", e.degen, degenerate); errors++;
        end
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic logic [IN_W-1:0] pack(int x, int y, int z);
    logic [CB-1:0] px, py, pz;
    px = CB'(x); py = CB'(y); pz = CB'(z);
    return {pz, py, px};
  endfunction

  function automatic int rnd_coord();
    case ($urandom_range(5))
      0: return $signed($urandom_range(2**CB - 1) << (32 - CB)) >>> (32 - CB);
      1: return $urandom_range(1) ? (2**(CB-1) - 1) : -(2**(CB-1));
      2: return 0;
      3: return int'($urandom_range(8191)) - 4096;
      default: return int'($urandom_range(2**17)) - 2**16;
    endcase
  endfunction

  function automatic logic [IN_W-1:0] rnd_point();
    return pack(rnd_coord(), rnd_coord(), rnd_coord());
  endfunction

  task automatic send_face(face_item_t it);
    int gap;
    cur <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    hits_q.push_back(trace_face(it, dims));
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(12);
      gap = (gap_max > 0) ? int'($urandom_range(gap_max)) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (hits_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_dims(logic [1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    dims = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_extremes();
    face_item_t it;
    int mx, mn;
    mx = 2**(CB-1) - 1;
    mn = -(2**(CB-1));
    it.org = '0; it.dir = '0; it.va = '0; it.vb = '0; it.vc = '0; it.ctr = '0;
    send_face(it);
    it.org = '1; it.dir = '1; it.va = '1; it.vb = '1; it.vc = '1; it.ctr = '1;
    send_face(it);
    it.org = pack(mn, mn, mn); it.dir = pack(mx, mx, mx);
    it.va = pack(mx, mn, mn); it.vb = pack(mn, mx, mn); it.vc = pack(mn, mn, mx);
    it.ctr = pack(mx, mx, mx);
    send_face(it);
    it.dir = pack(mn, mn, mn); it.ctr = pack(mn, mn, mn);
    send_face(it);
    it.org = pack(mx, mx, mx); it.dir = pack(1, 1, 1);
    it.va = pack(0, 0, 0); it.vb = pack(1, 0, 0); it.vc = pack(0, 1, 0);
    send_face(it);
  endtask

  task automatic test_special_cases();
    face_item_t it;
    // plain exit and entry through a unit triangle
    it.org = pack(256, 256, -1024); it.dir = pack(0, 0, 1024);
    it.va = pack(0, 0, 0); it.vb = pack(1024, 0, 0); it.vc = pack(0, 1024, 0);
    it.ctr = pack(300, 300, -500);
    send_face(it);
    it.ctr = pack(300, 300, 500);
    send_face(it);
    // centre in the face plane
    it.ctr = pack(100, 100, 0);
    send_face(it);
    // ray parallel to face
    it.dir = pack(1024, -512, 0);
    send_face(it);
    // coincident vertices, collinear vertices
    it.dir = pack(0, 0, 1024); it.vb = it.va;
    send_face(it);
    it.vb = pack(1024, 1024, 1024); it.vc = pack(2048, 2048, 2048);
    send_face(it);
    // hit on an edge and on a vertex, far miss
    it.vb = pack(1024, 0, 0); it.vc = pack(0, 1024, 0);
    it.org = pack(512, 0, -1024);
    send_face(it);
    it.org = pack(0, 0, -1024);
    send_face(it);
    it.org = pack(900000, -900000, -1024); it.dir = pack(0, 0, 1);
    send_face(it);
  endtask

  task automatic test_segment_faces();
    face_item_t it;
    write_dims(DIMS_2D);
    it.org = pack(512, -1024, 77); it.dir = pack(0, 1024, 5);
    it.va = pack(0, 0, 9); it.vb = pack(1024, 0, 3); it.vc = pack(-5, 99, 1);
    it.ctr = pack(512, 512, 4);
    send_face(it);
    it.ctr = pack(512, -512, 4);
    send_face(it);
    it.dir = pack(1024, 0, 8);
    send_face(it);
    it.vb = it.va;
    send_face(it);
    it.va = pack(0, 0, 1); it.vb = pack(0, 0, 2);
    send_face(it);
  endtask

  task automatic test_random(logic [1:0] nd, int count);
    face_item_t it;
    int k, sx, sy, sz;
    write_dims(nd);
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) begin
        stall_pct = $urandom_range(3) == 0 ? 0 : $urandom_range(70);
        gap_max = $urandom_range(3) == 0 ? 0 : $urandom_range(6);
      end
      it.org = rnd_point(); it.dir = rnd_point(); it.va = rnd_point();
      it.vb = rnd_point(); it.vc = rnd_point(); it.ctr = rnd_point();
      k = $urandom_range(9);
      if (k < 5) begin
        // well-formed: small face, ray aimed near it
        sx = int'($urandom_range(4096)) - 2048;
        sy = int'($urandom_range(4096)) - 2048;
        sz = int'($urandom_range(4096)) - 2048;
        it.va = pack(sx, sy, sz);
        it.vb = pack(sx + int'($urandom_range(4096)) - 2048, sy + int'($urandom_range(300)),
                     sz + int'($urandom_range(300)));
        it.vc = pack(sx + int'($urandom_range(300)), sy + int'($urandom_range(4096)) - 2048,
                     sz + int'($urandom_range(300)));
        it.org = pack(sx + int'($urandom_range(2000)) - 1000,
                      sy + int'($urandom_range(2000)) - 1000, sz - 3000);
        it.dir = pack(int'($urandom_range(600)) - 300, int'($urandom_range(600)) - 300,
                      int'($urandom_range(4096)) - 2048);
        it.ctr = pack(sx + 100, sy + 100, sz + int'($urandom_range(2000)) - 1000);
      end else if (k == 5) begin
        it.vb = it.va;
      end else if (k == 6) begin
        it.ctr = it.va;
      end else if (k == 7) begin
        it.dir = pack(int'(crd(it.vb, 0) - crd(it.va, 0)),
                      int'(crd(it.vb, 1) - crd(it.va, 1)),
                      int'(crd(it.vb, 2) - crd(it.va, 2)));
      end
      send_face(it);
    end
  endtask

  initial begin
    errors = 0;
    dims = DIMS_RESET;
    stall_pct = 0;
    gap_max = 0;
    burst_left = 0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    cur = '{default: '0};
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_extremes();
    test_special_cases();
    stall_pct = 30;
    gap_max = 3;
    test_segment_faces();
    test_random(DIMS_RESET, 600);
    test_random(DIMS_2D, 400);
    test_random(2'd0, 150);
    test_random(2'd1, 150);
    test_random(DIMS_RESET, 130);
    drain();
    if (errors == 0) begin
      $display("ray_simplex_face_intersect_top: match");
    end else begin
      $display("ray_simplex_face_intersect_top: mismatch");
    end
    $finish;
  end

endmodule
